[rtl/fces_pkg.sv]
package fces_pkg;

    // grid geometry
    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // rows_in_use / cols_in_use register width
    localparam int DIM_W    = 9;
    localparam logic [DIM_W-1:0] DIM_RST = 9'd256;

    localparam int COUNT_W  = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STAMP = 2'd2,
        OP_ROS   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CELL_UNBURNT    = 2'd0,
        CELL_BURNING    = 2'd1,
        CELL_UNBURNABLE = 2'd2,
        CELL_OTHER      = 2'd3
    } t_cell;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOURS_EN  = 3'd0,
        CFG_HOURS_THR = 3'd1,
        CFG_ROS_EN    = 3'd2,
        CFG_ROS_THR   = 3'd3,
        CFG_CONSUME   = 3'd4,
        CFG_ROWS      = 3'd5,
        CFG_COLS      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_cell      state;
        logic [7:0] hours;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_en;
        logic sweep_issue;
        logic result_cell;
        logic result_stamp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_is_stamp;
        logic stamp_new;
        logic grid_empty;
        logic clear_last;
        logic sweep_last;
    } t_stat;

endpackage

[rtl/fces_ram.sv]
module fces_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fces_ctrl.sv]
module fces_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fces_pkg::t_stat i_stat,
    output fces_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CELL   = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    priority if (!i_stat.op_is_stamp) n_state = ST_CELL;
                    else if (i_stat.stamp_new && !i_stat.grid_empty) n_state = ST_SWEEP;
                    else n_state = ST_RESULT;
                end
            end
            ST_CELL:   n_state = ST_IDLE;
            ST_SWEEP: begin
                if (i_stat.sweep_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_RESULT;
            ST_RESULT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept       = accept;
    assign o_cmd.clear_en     = (r_state == ST_CLEAR);
    assign o_cmd.sweep_issue  = (r_state == ST_SWEEP);
    assign o_cmd.result_cell  = (r_state == ST_CELL);
    assign o_cmd.result_stamp = (r_state == ST_RESULT);
    assign o_busy             = (r_state != ST_IDLE);

endmodule

[rtl/fces_dp.sv]
module fces_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fces_pkg::t_cmd                      i_cmd,
    output fces_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [fces_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fces_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [1:0]                          i_op,
    input  logic [7:0]                          i_row,
    input  logic [7:0]                          i_col,
    input  logic [1:0]                          i_new_cell_state,
    input  logic [7:0]                          i_new_burn_hours,
    input  logic [3:0]                          i_month,
    input  logic [4:0]                          i_day,
    input  logic [4:0]                          i_hour,
    input  logic [15:0]                         i_spread_rate,
    output logic                                o_valid,
    output logic                                o_status,
    output logic [1:0]                          o_cell_state_out,
    output logic [7:0]                          o_burn_hours_out,
    output logic                                o_extinguished,
    output logic                                o_swept,
    output logic [fces_pkg::COUNT_W-1:0]        o_cells_put_out
);

    localparam int ADDR_W  = fces_pkg::ADDR_W;
    localparam int DIM_W   = fces_pkg::DIM_W;
    localparam int COUNT_W = fces_pkg::COUNT_W;

    // configuration
    logic             r_hours_en;
    logic [7:0]       r_hours_thr;
    logic             r_ros_en;
    logic [15:0]      r_ros_thr;
    logic             r_consume;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours_en  <= 1'b0;
            r_hours_thr <= '0;
            r_ros_en    <= 1'b0;
            r_ros_thr   <= '0;
            r_consume   <= 1'b1;
            r_rows      <= fces_pkg::DIM_RST;
            r_cols      <= fces_pkg::DIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fces_pkg::CFG_HOURS_EN:  r_hours_en  <= i_cfg_wdata[0];
                fces_pkg::CFG_HOURS_THR: r_hours_thr <= i_cfg_wdata[7:0];
                fces_pkg::CFG_ROS_EN:    r_ros_en    <= i_cfg_wdata[0];
                fces_pkg::CFG_ROS_THR:   r_ros_thr   <= i_cfg_wdata[15:0];
                fces_pkg::CFG_CONSUME:   r_consume   <= i_cfg_wdata[0];
                fces_pkg::CFG_ROWS:      r_rows      <= i_cfg_wdata[DIM_W-1:0];
                fces_pkg::CFG_COLS:      r_cols      <= i_cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] eff_rows;
    logic [DIM_W-1:0] eff_cols;

    assign eff_rows = (int'(r_rows) > fces_pkg::MAX_ROWS) ? DIM_W'(fces_pkg::MAX_ROWS) : r_rows;
    assign eff_cols = (int'(r_cols) > fces_pkg::MAX_COLS) ? DIM_W'(fces_pkg::MAX_COLS) : r_cols;

    // request decode
    logic              in_range;
    logic              stamp_new;
    logic [ADDR_W-1:0] cell_addr;

    logic [3:0] r_last_month;
    logic [4:0] r_last_day;
    logic [4:0] r_last_hour;

    assign in_range  = (DIM_W'(i_row) < eff_rows) && (DIM_W'(i_col) < eff_cols);
    assign stamp_new = (i_month != r_last_month) || (i_day != r_last_day)
                    || (i_hour != r_last_hour);
    assign cell_addr = ADDR_W'(int'(i_row) * fces_pkg::MAX_COLS + int'(i_col));

    // latched request
    logic                 r_in_range;
    logic [1:0]           r_op;
    fces_pkg::t_entry     r_new;
    logic [15:0]          r_rate;
    logic [ADDR_W-1:0]    r_cell_addr;
    logic                 r_swept;

    // sweep walk and write-back stage
    logic [DIM_W-1:0]  r_srow;
    logic [DIM_W-1:0]  r_scol;
    logic [ADDR_W-1:0] r_sbase;
    logic [ADDR_W-1:0] sweep_addr;
    logic              col_last;
    logic              sweep_last;
    logic              r_wb_vld;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0] r_clr_addr;

    assign sweep_addr = r_sbase + ADDR_W'(r_scol);
    assign col_last   = (r_scol == eff_cols - DIM_W'(1));
    assign sweep_last = col_last && (r_srow == eff_rows - DIM_W'(1));

    // memory
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    fces_pkg::t_entry             ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [fces_pkg::ENTRY_W-1:0] ram_rdata;
    fces_pkg::t_entry             rd;

    assign ram_raddr = i_cmd.sweep_issue ? sweep_addr : cell_addr;
    assign rd        = fces_pkg::t_entry'(ram_rdata);

    fces_ram #(
        .WIDTH (fces_pkg::ENTRY_W),
        .DEPTH (fces_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // extinguished value
    fces_pkg::t_entry po;
    always_comb begin
        po.state = r_consume ? fces_pkg::CELL_UNBURNABLE : fces_pkg::CELL_UNBURNT;
        po.hours = '0;
    end

    // sweep write-back
    logic [7:0]       hrs_inc;
    logic             sw_burning;
    logic             sw_out;
    fces_pkg::t_entry sw_val;

    assign hrs_inc    = rd.hours + 8'd1;
    assign sw_burning = r_wb_vld && (rd.state == fces_pkg::CELL_BURNING);
    assign sw_out     = r_hours_en && (hrs_inc >= r_hours_thr);

    always_comb begin
        if (sw_out) begin
            sw_val = po;
        end else begin
            sw_val.state = fces_pkg::CELL_BURNING;
            sw_val.hours = hrs_inc;
        end
    end

    // cell op read-modify-write
    logic             cell_we;
    logic             cell_ext;
    fces_pkg::t_entry cell_val;

    always_comb begin
        cell_val = rd;
        cell_we  = 1'b0;
        cell_ext = 1'b0;
        if (r_in_range) begin
            unique case (r_op)
                fces_pkg::OP_WRITE: begin
                    cell_val = r_new;
                    cell_we  = 1'b1;
                end
                fces_pkg::OP_ROS: begin
                    if (r_ros_en && (r_rate < r_ros_thr)) begin
                        cell_val = po;
                        cell_we  = 1'b1;
                        cell_ext = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wb_addr;
        ram_wdata = sw_val;
        priority if (i_cmd.clear_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.result_cell && cell_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_cell_addr;
            ram_wdata = cell_val;
        end else if (sw_burning) begin
            ram_we    = 1'b1;
        end else begin
            ram_we    = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_wb_vld     <= 1'b0;
            r_last_month <= '0;
            r_last_day   <= '0;
            r_last_hour  <= '0;
            r_count      <= '0;
            r_swept      <= 1'b0;
            r_srow       <= '0;
            r_scol       <= '0;
            r_sbase      <= '0;
        end else begin
            r_wb_vld <= i_cmd.sweep_issue;
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.accept) begin
                r_count <= '0;
                r_swept <= stamp_new;
                r_srow  <= '0;
                r_scol  <= '0;
                r_sbase <= '0;
                if ((i_op == fces_pkg::OP_STAMP) && stamp_new) begin
                    r_last_month <= i_month;
                    r_last_day   <= i_day;
                    r_last_hour  <= i_hour;
                end
            end else begin
                if (sw_burning && sw_out && (r_count != fces_pkg::COUNT_MAX)) begin
                    r_count <= r_count + COUNT_W'(1);
                end
                if (i_cmd.sweep_issue) begin
                    if (col_last) begin
                        r_scol  <= '0;
                        r_srow  <= r_srow + DIM_W'(1);
                        r_sbase <= r_sbase + ADDR_W'(fces_pkg::MAX_COLS);
                    end else begin
                        r_scol  <= r_scol + DIM_W'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wb_addr <= sweep_addr;
        if (i_cmd.accept) begin
            r_in_range  <= in_range;
            r_op        <= i_op;
            r_new.state <= fces_pkg::t_cell'(i_new_cell_state);
            r_new.hours <= i_new_burn_hours;
            r_rate      <= i_spread_rate;
            r_cell_addr <= cell_addr;
        end
    end

    // result register
    logic               r_valid;
    logic               r_status;
    logic [1:0]         r_cs_out;
    logic [7:0]         r_bh_out;
    logic               r_ext;
    logic               r_swept_out;
    logic [COUNT_W-1:0] r_count_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.result_cell || i_cmd.result_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_cell) begin
            r_status    <= !r_in_range;
            r_cs_out    <= r_in_range ? cell_val.state : 2'd0;
            r_bh_out    <= r_in_range ? cell_val.hours : 8'd0;
            r_ext       <= cell_ext;
            r_swept_out <= 1'b0;
            r_count_out <= '0;
        end else if (i_cmd.result_stamp) begin
            r_status    <= 1'b0;
            r_cs_out    <= 2'd0;
            r_bh_out    <= 8'd0;
            r_ext       <= 1'b0;
            r_swept_out <= r_swept;
            r_count_out <= r_count;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_cell_state_out = r_cs_out;
    assign o_burn_hours_out = r_bh_out;
    assign o_extinguished   = r_ext;
    assign o_swept          = r_swept_out;
    assign o_cells_put_out  = r_count_out;

    assign o_stat.op_is_stamp = (i_op == fces_pkg::OP_STAMP);
    assign o_stat.stamp_new   = stamp_new;
    assign o_stat.grid_empty  = (eff_rows == '0) || (eff_cols == '0);
    assign o_stat.clear_last  = (r_clr_addr == ADDR_W'(fces_pkg::DEPTH - 1));
    assign o_stat.sweep_last  = sweep_last;

    // checks
    a_wb_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> $past(i_cmd.sweep_issue))
        else $error("sweep write-back without a read issued");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            (o_cell_state_out == 2'd0 && o_burn_hours_out == 8'd0 && !o_extinguished))
        else $error("out-of-grid result carries cell data");

    a_count_needs_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_cells_put_out != '0)) |-> o_swept)
        else $error("cells put out without a sweep");

endmodule

[rtl/fire_cell_extinction_sweep_top.sv]
// Fire-cell extinction sweep. Holds a MAX_ROWS x MAX_COLS grid of 2-bit cell
// states and 8-bit burn-hour counters in one block RAM. After reset the block
// runs a clearing pass over the whole RAM, one entry per cycle, with o_busy
// high; configuration writes are taken during that pass. A request is taken
// when i_start is high and o_busy is low. For write, read and rate-check
// requests the accept edge reads the cell, the next edge writes it back and
// loads the result. A time stamp equal to the stored one, or a new one while
// the grid in use is empty, goes straight to loading the result. A new time
// stamp walks the rows and columns in use at one cell per cycle through the
// RAM's read and write ports; a drain state then finishes the last write-back
// before the result loads. The result appears on the o_ fields for exactly
// one cycle with o_valid high; there is no back-pressure, so the receiver
// must capture it then. Because of the output register, the next request can
// be issued in the cycle o_valid is high. Configuration must only be written
// while no request is in flight.
module fire_cell_extinction_sweep_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // request channel
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_op,
    input  logic [7:0]                      i_row,
    input  logic [7:0]                      i_col,
    input  logic [1:0]                      i_new_cell_state,
    input  logic [7:0]                      i_new_burn_hours,
    input  logic [3:0]                      i_month,
    input  logic [4:0]                      i_day,
    input  logic [4:0]                      i_hour,
    input  logic [15:0]                     i_spread_rate,

    // result channel, one-cycle strobe
    output logic                            o_valid,
    output logic                            o_status,
    output logic [1:0]                      o_cell_state_out,
    output logic [7:0]                      o_burn_hours_out,
    output logic                            o_extinguished,
    output logic                            o_swept,
    output logic [fces_pkg::COUNT_W-1:0]    o_cells_put_out,

    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fces_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fces_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    fces_pkg::t_cmd  cmd;   // sequencer commands
    fces_pkg::t_stat stat;  // datapath status back to the sequencer

    // Sequencer: clearing pass, cell read-modify-write, sweep walk, result.
    fces_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // Datapath: config registers, grid RAM, sweep counters, result register.
    fces_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_op             (i_op),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_new_cell_state (i_new_cell_state),
        .i_new_burn_hours (i_new_burn_hours),
        .i_month          (i_month),
        .i_day            (i_day),
        .i_hour           (i_hour),
        .i_spread_rate    (i_spread_rate),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_cell_state_out (o_cell_state_out),
        .o_burn_hours_out (o_burn_hours_out),
        .o_extinguished   (o_extinguished),
        .o_swept          (o_swept),
        .o_cells_put_out  (o_cells_put_out)
    );

endmodule
